// ===== rtl/ajb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ajb_pkg;

	localparam int FIFO_DEPTH       = 4096;
	localparam int ADDR_W           = $clog2(FIFO_DEPTH);
	localparam int FILL_W           = ADDR_W + 1;
	localparam int MAX_BLOCK_FRAMES = 16;
	localparam int MAX_CHANNELS     = 4;
	localparam int FRAME_W          = 4;
	localparam int CHAN_W           = 2;
	localparam int FRAMES_W         = 5;
	localparam int CHANS_W          = 3;
	localparam int SPARE_W          = 7;
	localparam int MAXQ_W           = 8;
	localparam int BLOCK_W          = $clog2(MAX_BLOCK_FRAMES * MAX_CHANNELS + 1);
	localparam int PROD_W           = 15;
	localparam int SAMPLE_W         = 24;
	localparam int CFG_DATA_W       = 8;
	localparam int CFG_IDX_W        = 2;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_RENDER = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_FRAMES  = 2'd0,
		REG_CHANNEL_COUNT = 2'd1,
		REG_SPARE_LATENCY = 2'd2,
		REG_MAX_QUEUE     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                 operation;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_start;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic [CHAN_W-1:0]          channel;
		logic [FRAME_W-1:0]         frame;
		logic                       silent;
		logic                       last;
	} result_t;

	typedef struct packed {
		logic push;
		logic render;
		logic clear;
		logic beat;
	} ajb_cmd_t;

	typedef struct packed {
		logic last_beat;
	} ajb_status_t;

	function automatic logic [FRAMES_W-1:0] eff_frames(input logic [FRAMES_W-1:0] v);
		if (v == '0) begin
			return FRAMES_W'(1);
		end else if (v > FRAMES_W'(MAX_BLOCK_FRAMES)) begin
			return FRAMES_W'(MAX_BLOCK_FRAMES);
		end
		return v;
	endfunction

	function automatic logic [CHANS_W-1:0] eff_chans(input logic [CHANS_W-1:0] v);
		if (v == '0) begin
			return CHANS_W'(1);
		end else if (v > CHANS_W'(MAX_CHANNELS)) begin
			return CHANS_W'(MAX_CHANNELS);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/audio_jitter_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// push and clear are accepted back to back, busy stays low
// render: results one per cycle, first one via the state register and the s1 stage, busy
//   until the last beat, next item accepted after that (one fifo read port)
// results are strobed for one cycle, the receiver cannot stall
// reset: fifo empty, prebuffering, silence armed, registers 16/2/0/8

module audio_jitter_buffer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire ajb_pkg::in_item_t                item,
	input  wire logic                             cfg_we,
	input  wire logic [ajb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ajb_pkg::CFG_DATA_W-1:0]   cfg_data,
	output ajb_pkg::result_t                      result,
	output logic                                  result_strobe
);
	import ajb_pkg::*;

	ajb_cmd_t    cmd;
	ajb_status_t status;

	ajb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.status    (status),
		.busy      (busy),
		.cmd       (cmd)
	);

	ajb_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item          (item),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.status        (status),
		.result        (result),
		.result_strobe (result_strobe)
	);

	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (item.operation == OP_RENDER) |=> busy)
		else $error("render item did not raise busy");

	a_block_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |=> result_strobe)
		else $error("gap inside a rendered block");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |-> !busy)
		else $error("busy still high at final result");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.silent |-> (result.sample_out == '0))
		else $error("silent result carries a nonzero sample");

endmodule

`default_nettype wire

// ===== rtl/ajb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ajb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [1:0]          operation,
	input  wire ajb_pkg::ajb_status_t status,
	output logic                     busy,
	output ajb_pkg::ajb_cmd_t        cmd
);
	import ajb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		cmd.push   = accept && (operation == OP_PUSH);
		cmd.render = accept && (operation == OP_RENDER);
		cmd.clear  = accept && (operation == OP_CLEAR);
		cmd.beat   = (state_q == ST_RUN);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.render) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (status.last_beat) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ajb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ajb_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ajb_pkg::ajb_cmd_t                   cmd,
	input  wire ajb_pkg::in_item_t                   item,
	input  wire logic                                cfg_we,
	input  wire logic [ajb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [ajb_pkg::CFG_DATA_W-1:0]      cfg_data,
	output ajb_pkg::ajb_status_t                     status,
	output ajb_pkg::result_t                         result,
	output logic                                     result_strobe
);
	import ajb_pkg::*;

	logic [SAMPLE_W-1:0] mem [FIFO_DEPTH];

	logic [ADDR_W-1:0]   rd_ptr_q;
	logic [ADDR_W-1:0]   wr_ptr_q;
	logic [FILL_W-1:0]   fill_q;
	logic                prebuf_q;
	logic                pending_q;
	logic                dropping_q;
	logic                silent_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [CHAN_W-1:0]   chan_q;

	logic [FRAMES_W-1:0] frames_q;
	logic [CHANS_W-1:0]  chans_q;
	logic [SPARE_W-1:0]  spare_q;
	logic [MAXQ_W-1:0]   maxq_q;
	logic [BLOCK_W-1:0]  block_q;

	logic                valid_s1;
	logic [FRAME_W-1:0]  frame_s1;
	logic [CHAN_W-1:0]   chan_s1;
	logic                last_s1;
	logic                silent_s1;
	logic [SAMPLE_W-1:0] rdata_s1;

	logic [PROD_W-1:0]   limit;
	logic [PROD_W-1:0]   need;
	logic [PROD_W-1:0]   fill_x;
	logic                overflow;
	logic                wr_en;
	logic                pre_wait;
	logic                underrun;
	logic                last_beat;
	logic [FRAMES_W-1:0] new_frames;
	logic [CHANS_W-1:0]  new_chans;
	logic [SPARE_W-1:0]  new_spare;

	assign fill_x = PROD_W'(fill_q);
	assign limit  = PROD_W'(maxq_q) * PROD_W'(block_q);
	assign need   = (PROD_W'(spare_q) + PROD_W'(1)) * PROD_W'(block_q);

	assign overflow = item.block_start && (fill_x > limit);
	assign wr_en    = cmd.push && !overflow && (item.block_start || !dropping_q)
		&& (fill_q != FILL_W'(FIFO_DEPTH));
	assign pre_wait = prebuf_q && (fill_x < need);
	assign underrun = !pre_wait && (fill_q < FILL_W'(block_q));

	assign last_beat = (FRAMES_W'(frame_q) + FRAMES_W'(1) == frames_q)
		&& (CHANS_W'(chan_q) + CHANS_W'(1) == chans_q);
	assign status.last_beat = last_beat;

	assign new_frames = eff_frames(cfg_data[FRAMES_W-1:0]);
	assign new_chans  = eff_chans(cfg_data[CHANS_W-1:0]);
	assign new_spare  = cfg_data[SPARE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			fill_q     <= '0;
			prebuf_q   <= 1'b1;
			pending_q  <= 1'b1;
			dropping_q <= 1'b0;
			silent_q   <= 1'b0;
			frame_q    <= '0;
			chan_q     <= '0;
			valid_s1   <= 1'b0;
			frames_q   <= FRAMES_W'(16);
			chans_q    <= CHANS_W'(2);
			spare_q    <= '0;
			maxq_q     <= MAXQ_W'(8);
			block_q    <= BLOCK_W'(32);
		end else begin
			valid_s1 <= cmd.beat;
			if (cmd.push) begin
				if (overflow) begin
					rd_ptr_q   <= wr_ptr_q;
					fill_q     <= '0;
					pending_q  <= 1'b1;
					dropping_q <= 1'b1;
				end else begin
					if (item.block_start) dropping_q <= 1'b0;
					if (wr_en) begin
						wr_ptr_q <= wr_ptr_q + ADDR_W'(1);
						fill_q   <= fill_q + FILL_W'(1);
					end
				end
			end
			if (cmd.clear) begin
				rd_ptr_q  <= wr_ptr_q;
				fill_q    <= '0;
				pending_q <= 1'b1;
			end
			if (cmd.render) begin
				frame_q  <= '0;
				chan_q   <= '0;
				silent_q <= pending_q || pre_wait || underrun;
				if (pending_q) begin
					pending_q <= 1'b0;
					prebuf_q  <= 1'b1;
				end else if (!pre_wait) begin
					if (underrun) begin
						rd_ptr_q <= wr_ptr_q;
						fill_q   <= '0;
						prebuf_q <= 1'b1;
					end else begin
						prebuf_q <= 1'b0;
					end
				end
			end
			if (cmd.beat) begin
				if (!silent_q) begin
					rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
					fill_q   <= fill_q - FILL_W'(1);
				end
				if (CHANS_W'(chan_q) + CHANS_W'(1) == chans_q) begin
					chan_q  <= '0;
					frame_q <= frame_q + FRAME_W'(1);
				end else begin
					chan_q <= chan_q + CHAN_W'(1);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BLOCK_FRAMES: begin
						frames_q  <= new_frames;
						block_q   <= BLOCK_W'(new_frames) * BLOCK_W'(chans_q);
						rd_ptr_q  <= wr_ptr_q;
						fill_q    <= '0;
						pending_q <= 1'b1;
					end
					REG_CHANNEL_COUNT: begin
						chans_q  <= new_chans;
						block_q  <= BLOCK_W'(frames_q) * BLOCK_W'(new_chans);
						rd_ptr_q <= wr_ptr_q;
						fill_q   <= '0;
					end
					REG_SPARE_LATENCY: begin
						spare_q  <= new_spare;
						rd_ptr_q <= wr_ptr_q;
						fill_q   <= '0;
						if (new_spare != spare_q) pending_q <= 1'b1;
					end
					REG_MAX_QUEUE: begin
						maxq_q <= cfg_data[MAXQ_W-1:0];
					end
					default: ;
				endcase
			end
		end
	end

	// fifo store and read stage
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_ptr_q] <= item.sample;
		if (cmd.beat && !silent_q) rdata_s1 <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.beat) begin
			frame_s1  <= frame_q;
			chan_s1   <= chan_q;
			last_s1   <= last_beat;
			silent_s1 <= silent_q;
		end
	end

	always_comb begin
		result.sample_out = silent_s1 ? '0 : rdata_s1;
		result.channel    = chan_s1;
		result.frame      = frame_s1;
		result.silent     = silent_s1;
		result.last       = last_s1;
	end

	assign result_strobe = valid_s1;

endmodule

`default_nettype wire

// ===== tb/sv/tb_audio_jitter_buffer.sv =====
`timescale 1ns / 1ps

module tb_audio_jitter_buffer;
	import ajb_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	in_item_t              item = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	result_t               result;
	logic                  result_strobe;

	audio_jitter_buffer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result        (result),
		.result_strobe (result_strobe)
	);

	always #2 clk = ~clk;

	// playout model state
	logic [SAMPLE_W-1:0] sample_fifo [FIFO_DEPTH];
	logic [ADDR_W-1:0]   rd_ptr = '0;
	logic [ADDR_W-1:0]   wr_ptr = '0;
	int unsigned         queued = 0;
	bit                  prebuffer = 1'b1;
	bit                  silence_armed = 1'b1;
	bit                  skipping_block = 1'b0;
	logic [FRAMES_W-1:0] frames_reg = FRAMES_W'(16);
	logic [CHANS_W-1:0]  chans_reg = CHANS_W'(2);
	logic [SPARE_W-1:0]  spare_reg = '0;
	logic [MAXQ_W-1:0]   maxq_reg = MAXQ_W'(8);

	in_item_t pending [$];
	result_t  playout_q [$];
	result_t  want_r;
	int       gap_left = 0;
	bit       steady = 1'b0;
	int       fails = 0;

	int n_push = 0, n_render = 0, n_clear = 0, n_noise = 0, n_checked = 0;
	int n_overflow = 0, n_full = 0, n_underrun = 0, n_played = 0;

	function automatic int unsigned frames_now();
		if (frames_reg == 0) begin
			return 1;
		end
		return (frames_reg > MAX_BLOCK_FRAMES) ? MAX_BLOCK_FRAMES : frames_reg;
	endfunction

	function automatic int unsigned chans_now();
		if (chans_reg == 0) begin
			return 1;
		end
		return (chans_reg > MAX_CHANNELS) ? MAX_CHANNELS : chans_reg;
	endfunction

	task automatic flush_fifo();
		rd_ptr = wr_ptr;
		queued = 0;
	endtask

	task automatic apply_setting(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_BLOCK_FRAMES: begin
				frames_reg = value[FRAMES_W-1:0];
				flush_fifo();
				silence_armed = 1'b1;
			end
			REG_CHANNEL_COUNT: begin
				chans_reg = value[CHANS_W-1:0];
				flush_fifo();
			end
			REG_SPARE_LATENCY: begin
				flush_fifo();
				if (value[SPARE_W-1:0] != spare_reg) begin
					silence_armed = 1'b1;
				end
				spare_reg = value[SPARE_W-1:0];
			end
			default: begin
				maxq_reg = value[MAXQ_W-1:0];
			end
		endcase
	endtask

	task automatic play_item(input in_item_t it);
		int unsigned fr, ch, blk, k;
		bit mute;
		result_t r;
		fr = frames_now();
		ch = chans_now();
		blk = fr * ch;
		case (it.operation)
			OP_PUSH: begin
				n_push++;
				if (it.block_start) begin
					if (queued > maxq_reg * blk) begin
						flush_fifo();
						silence_armed = 1'b1;
						skipping_block = 1'b1;
						n_overflow++;
						return;
					end
					skipping_block = 1'b0;
				end
				if (skipping_block) begin
					return;
				end
				if (queued >= FIFO_DEPTH) begin
					n_full++;
					return;
				end
				sample_fifo[wr_ptr] = it.sample;
				wr_ptr++;
				queued++;
			end
			OP_RENDER: begin
				n_render++;
				mute = 1'b0;
				if (silence_armed) begin
					silence_armed = 1'b0;
					prebuffer = 1'b1;
					mute = 1'b1;
				end else begin
					if (prebuffer) begin
						if (queued < (1 + spare_reg) * blk) begin
							mute = 1'b1;
						end else begin
							prebuffer = 1'b0;
						end
					end
					if (!mute && queued < blk) begin
						flush_fifo();
						prebuffer = 1'b1;
						mute = 1'b1;
						n_underrun++;
					end
				end
				if (!mute) begin
					n_played++;
				end
				k = 0;
				for (int f = 0; f < fr; f++) begin
					for (int c = 0; c < ch; c++) begin
						r = '0;
						if (!mute) begin
							r.sample_out = sample_fifo[rd_ptr];
							rd_ptr++;
							queued--;
						end
						r.channel = CHAN_W'(c);
						r.frame = FRAME_W'(f);
						r.silent = mute;
						r.last = (k + 1 == blk);
						playout_q.push_back(r);
						k++;
					end
				end
			end
			OP_CLEAR: begin
				n_clear++;
				flush_fifo();
				silence_armed = 1'b1;
			end
			default: begin
				n_noise++;
			end
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		if (start && !busy) begin
			play_item(pending.pop_front());
			if (!steady && $urandom_range(0, 4) == 0) begin
				gap_left = $urandom_range(1, 17);
			end
		end
		if (!steady && gap_left == 0 && $urandom_range(0, 60) == 0) begin
			gap_left = $urandom_range(1, 17);
		end
		if (!steady && gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (pending.size() != 0) begin
			start <= 1'b1;
			item <= pending[0];
		end else begin
			start <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (playout_q.size() == 0) begin
				$error("result with no sample expected");
				fails++;
			end else begin
				want_r = playout_q.pop_front();
				n_checked++;
				check_field("sample_out", want_r.sample_out, result.sample_out);
				check_field("channel", want_r.channel, result.channel);
				check_field("frame", want_r.frame, result.frame);
				check_field("silent", want_r.silent, result.silent);
				check_field("last", want_r.last, result.last);
			end
		end
	end

	function automatic in_item_t make_item(input logic [1:0] op, input logic [SAMPLE_W-1:0] s,
			input bit bs);
		in_item_t it;
		it.operation = op;
		it.sample = s;
		it.block_start = bs;
		return it;
	endfunction

	function automatic logic [SAMPLE_W-1:0] any_sample();
		case ($urandom_range(0, 11))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic queue_block(input int n, input bit with_start);
		for (int i = 0; i < n; i++) begin
			pending.push_back(make_item(OP_PUSH, any_sample(), with_start && i == 0));
		end
	endtask

	task automatic queue_op(input logic [1:0] op);
		pending.push_back(make_item(op, SAMPLE_W'($urandom()), 1'($urandom_range(0, 1))));
	endtask

	task automatic feed(input int quota);
		int taken, blk, r, n;
		taken = 0;
		blk = frames_now() * chans_now();
		while (taken < quota) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				queue_block(blk, 1'b1);
				taken += blk;
			end else if (r < 80) begin
				queue_op(OP_RENDER);
				taken++;
			end else if (r < 86) begin
				queue_op(OP_CLEAR);
				taken++;
			end else if (r < 95) begin
				n = $urandom_range(1, blk);
				queue_block(n, 1'($urandom_range(0, 1)));
				taken += n;
			end else begin
				queue_op(OP_UNUSED);
			end
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		apply_setting(idx, value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every item is taken and every sample has come out
	task automatic settle();
		int waited;
		waited = 0;
		while ((pending.size() != 0 || start || playout_q.size() != 0) && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		if (waited >= 200000) begin
			$error("stalled with %0d items and %0d samples outstanding",
				pending.size(), playout_q.size());
			fails++;
			pending.delete();
			playout_q.delete();
		end
		repeat (24) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-sample blocks, upper register bits set
		write_reg(REG_BLOCK_FRAMES, 8'hE1);
		write_reg(REG_CHANNEL_COUNT, 8'hF9);
		write_reg(REG_SPARE_LATENCY, 8'd0);
		write_reg(REG_MAX_QUEUE, 8'd2);
		queue_op(OP_RENDER);
		queue_op(OP_UNUSED);
		queue_op(OP_RENDER);
		pending.push_back(make_item(OP_PUSH, 24'h800000, 1'b1));
		pending.push_back(make_item(OP_PUSH, 24'h7FFFFF, 1'b1));
		queue_op(OP_RENDER);
		queue_op(OP_RENDER);
		queue_op(OP_RENDER);
		pending.push_back(make_item(OP_PUSH, 24'h000000, 1'b1));
		pending.push_back(make_item(OP_PUSH, 24'hFFFFFF, 1'b0));
		pending.push_back(make_item(OP_PUSH, 24'h555555, 1'b1));
		pending.push_back(make_item(OP_PUSH, 24'hAAAAAA, 1'b1));
		pending.push_back(make_item(OP_PUSH, 24'h123456, 1'b0));
		pending.push_back(make_item(OP_PUSH, 24'h654321, 1'b1));
		queue_op(OP_RENDER);
		queue_op(OP_RENDER);
		queue_op(OP_UNUSED);
		pending.push_back(make_item(OP_PUSH, 24'h000001, 1'b1));
		queue_op(OP_CLEAR);
		queue_op(OP_RENDER);
		queue_op(OP_RENDER);
		settle();

		write_reg(REG_BLOCK_FRAMES, 8'd2);
		write_reg(REG_CHANNEL_COUNT, 8'd2);
		write_reg(REG_SPARE_LATENCY, 8'd0);
		write_reg(REG_MAX_QUEUE, 8'd3);
		feed(18);
		settle();

		// same spare latency again: fifo emptied, no silence armed
		write_reg(REG_CHANNEL_COUNT, 8'd2);
		write_reg(REG_SPARE_LATENCY, 8'd0);
		feed(8);
		settle();

		write_reg(REG_BLOCK_FRAMES, 8'd0);
		write_reg(REG_CHANNEL_COUNT, 8'd4);
		write_reg(REG_SPARE_LATENCY, 8'd1);
		write_reg(REG_MAX_QUEUE, 8'd1);
		feed(16);
		settle();

		write_reg(REG_BLOCK_FRAMES, 8'd3);
		write_reg(REG_CHANNEL_COUNT, 8'd0);
		write_reg(REG_SPARE_LATENCY, 8'd2);
		write_reg(REG_MAX_QUEUE, 8'd255);
		feed(16);
		settle();

		// largest blocks, prebuffer target beyond the fifo: never plays
		write_reg(REG_BLOCK_FRAMES, 8'h1F);
		write_reg(REG_CHANNEL_COUNT, 8'h07);
		write_reg(REG_MAX_QUEUE, 8'd255);
		write_reg(REG_SPARE_LATENCY, 8'd127);
		write_reg(REG_SPARE_LATENCY, 8'd64);
		queue_block(8, 1'b1);
		repeat (3) queue_op(OP_RENDER);
		settle();

		steady = 1'b1;
		write_reg(REG_BLOCK_FRAMES, 8'd4);
		write_reg(REG_CHANNEL_COUNT, 8'd2);
		write_reg(REG_SPARE_LATENCY, 8'd0);
		write_reg(REG_MAX_QUEUE, 8'd4);
		feed(16);
		settle();

		$display("covered %0d pushes, %0d renders (%0d played), %0d clears, %0d ignored ops",
			n_push, n_render, n_played, n_clear, n_noise);
		$display("%0d samples checked, %0d overflow drops, %0d full-fifo drops, %0d underruns",
			n_checked, n_overflow, n_full, n_underrun);
		if (fails == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ajb_pkg.sv
rtl/ajb_ctrl.sv
rtl/ajb_datapath.sv
rtl/audio_jitter_buffer.sv
tb/sv/tb_audio_jitter_buffer.sv
